### rtl/bbal_pkg.sv
// Shared constants and payload types for the least-loaded bin balancer.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package bbal_pkg;

  // Batch capacity, bin count and item size width.
  localparam int MAX_ITEMS = 64;
  localparam int MAX_BINS  = 16;
  localparam int SIZE_BITS = 48;

  // Widths fixed by the field definitions of the channels.
  localparam int IDX_BITS  = 6;   // item_index
  localparam int BIN_BITS  = 4;   // bin_index
  localparam int LOAD_BITS = 54;  // bin_load
  localparam int BCFG_BITS = 5;   // bin_count register

  // Item counter holds 0 .. MAX_ITEMS, bin sweep counter holds 0 .. MAX_BINS.
  localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);
  localparam int BSEL_BITS = $clog2(MAX_BINS + 1);

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [LOAD_BITS-1:0] load_t;

endpackage

`default_nettype wire

### rtl/bbal_if.sv
// Channel interfaces of the bin balancer: item requests, result requests and
// the bin_count configuration write. Depends on bbal_pkg for payload types.
`timescale 1ns / 1ps
`default_nettype none

interface bbal_in_if;
  logic           valid;
  logic           ready;
  bbal_pkg::size_t item_size;
  logic           last_item;

  modport source (output valid, output item_size, output last_item, input ready);
  modport sink   (input valid, input item_size, input last_item, output ready);
endinterface

interface bbal_out_if;
  logic                          valid;
  logic                          ready;
  logic [bbal_pkg::IDX_BITS-1:0] item_index;
  logic [bbal_pkg::BIN_BITS-1:0] bin_index;
  bbal_pkg::load_t               bin_load;
  logic                          dropped;
  logic                          last_result;

  modport source (output valid, output item_index, output bin_index, output bin_load,
                  output dropped, output last_result, input ready);
  modport sink   (input valid, input item_index, input bin_index, input bin_load,
                  input dropped, input last_result, output ready);
endinterface

interface bbal_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bbal_pkg::BCFG_BITS-1:0] bin_count;

  modport source (output valid, output bin_count, input ready);
  modport sink   (input valid, input bin_count, output ready);
endinterface

`default_nettype wire

### rtl/greedy_least_loaded_bin_balancer_core.sv
// Top level of the greedy least-loaded bin balancer (largest item first).
// Depends on bbal_pkg and on the channel interfaces in bbal_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   in_i carries item requests (item_size, last_item). Items are stored one per
//   cycle while the block is loading; the request with last_item set closes the
//   batch. Requests beyond MAX_ITEMS are discarded and the batch is flagged.
//   out_o carries one result request per stored item, largest size first
//   (equal sizes in arrival order), with the chosen bin and its new load.
//   cfg_i writes bin_count at any time; the value is sampled when the last item
//   of a batch is accepted. Zero means one bin, values above MAX_BINS saturate.
// Timing
//   After the last item, the ranking pass compares every stored size against
//   every other through the single read port of the size memory. Each
//   assignment then reads its arrival index and size and runs the bin sweep
//   of the shared comparator before its result is registered.
//   in_i is not ready from the last item until the final result is registered.
// Reset clears the batch, the bin loads and the output valid flag and sets
//   bin_count to one. If out_o stalls, the next result waits in the sequencer
//   until the output register is free; nothing is lost or repeated.

module greedy_least_loaded_bin_balancer_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  bbal_in_if.sink    in_i,
  bbal_out_if.source out_o,
  bbal_cfg_if.sink   cfg_i
);

  localparam int IDXB = bbal_pkg::IDX_BITS;
  localparam int CNTB = bbal_pkg::CNT_BITS;
  localparam int BINB = bbal_pkg::BIN_BITS;
  localparam int BSLB = bbal_pkg::BSEL_BITS;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_LOAD     = 8'b0000_0001,  // accepting item requests
    S_RK_FETCH = 8'b0000_0010,  // read size of the item being ranked
    S_RK_SWEEP = 8'b0000_0100,  // compare it against every stored size
    S_RK_WR    = 8'b0000_1000,  // write its arrival index at its rank
    S_AS_ORD   = 8'b0001_0000,  // read next arrival index in sorted order
    S_AS_SIZE  = 8'b0010_0000,  // read its size, start the bin sweep
    S_AS_MIN   = 8'b0100_0000,  // find the least loaded bin
    S_AS_PUSH  = 8'b1000_0000   // update the bin and register the result
  } state_e;

  state_e state_q, state_d;

  logic [CNTB-1:0]           cnt_q, cnt_d;
  logic                      ovf_q, ovf_d;
  logic [bbal_pkg::BCFG_BITS-1:0] bincfg_q, bincfg_d;
  logic [BSLB-1:0]           bins_q, bins_d;
  logic [IDXB-1:0]           i_q, i_d;
  logic [CNTB-1:0]           j_q, j_d;
  logic [IDXB-1:0]           jp_q, jp_d;
  logic                      cmp_vld_q, cmp_vld_d;
  logic [IDXB-1:0]           rank_q, rank_d;
  bbal_pkg::size_t           si_q, si_d;
  logic [IDXB-1:0]           k_q, k_d;
  logic [IDXB-1:0]           idx_q, idx_d;
  logic [BSLB-1:0]           b_q, b_d;
  logic [BINB-1:0]           best_q, best_d;
  bbal_pkg::load_t           best_load_q, best_load_d;
  bbal_pkg::load_t           loads_q [bbal_pkg::MAX_BINS];
  bbal_pkg::load_t           loads_d [bbal_pkg::MAX_BINS];

  logic                      out_vld_q, out_vld_d;
  logic                      out_ld;
  logic [IDXB-1:0]           out_idx_q;
  logic [BINB-1:0]           out_bin_q;
  bbal_pkg::load_t           out_load_q;
  logic                      out_drop_q;
  logic                      out_last_q;

  // Size memory: one write port for loading, one registered read port.
  bbal_pkg::size_t           size_mem [bbal_pkg::MAX_ITEMS];
  bbal_pkg::size_t           size_rd_q;
  logic                      size_we;
  logic [IDXB-1:0]           size_raddr;

  // Order memory: sorted position to arrival index.
  logic [IDXB-1:0]           ord_mem [bbal_pkg::MAX_ITEMS];
  logic [IDXB-1:0]           ord_rd_q;
  logic                      ord_we;

  logic                      in_acc;
  logic                      greater;
  logic                      push_ok;
  logic                      res_last;
  bbal_pkg::load_t           sum;
  logic [CNTB-1:0]           i_next;
  logic [CNTB-1:0]           k_next;

  assign in_i.ready  = (state_q == S_LOAD);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;

  assign out_o.valid       = out_vld_q;
  assign out_o.item_index  = out_idx_q;
  assign out_o.bin_index   = out_bin_q;
  assign out_o.bin_load    = out_load_q;
  assign out_o.dropped     = out_drop_q;
  assign out_o.last_result = out_last_q;

  // Ranking order: a stored item counts against the ranked one if it is larger,
  // or equal in size and earlier in arrival.
  assign greater = (size_rd_q > si_q) || ((size_rd_q == si_q) && (jp_q < i_q));

  assign i_next   = CNTB'(i_q) + 1'b1;
  assign k_next   = CNTB'(k_q) + 1'b1;
  assign res_last = (k_next == cnt_q);
  assign sum      = best_load_q + bbal_pkg::LOAD_BITS'(size_rd_q);
  assign push_ok  = !out_vld_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    bincfg_d    = bincfg_q;
    bins_d      = bins_q;
    i_d         = i_q;
    j_d         = j_q;
    jp_d        = jp_q;
    cmp_vld_d   = 1'b0;
    rank_d      = rank_q;
    si_d        = si_q;
    k_d         = k_q;
    idx_d       = idx_q;
    b_d         = b_q;
    best_d      = best_q;
    best_load_d = best_load_q;
    loads_d     = loads_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_ld      = 1'b0;
    size_we     = 1'b0;
    ord_we      = 1'b0;
    size_raddr  = idx_q;

    if (cfg_i.valid) begin
      bincfg_d = cfg_i.bin_count;
    end

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_q < CNTB'(bbal_pkg::MAX_ITEMS)) begin
            size_we = 1'b1;
            cnt_d   = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last_item) begin
            if (bincfg_q == '0) begin
              bins_d = BSLB'(1);
            end else if (BSLB'(bincfg_q) > BSLB'(bbal_pkg::MAX_BINS)) begin
              bins_d = BSLB'(bbal_pkg::MAX_BINS);
            end else begin
              bins_d = BSLB'(bincfg_q);
            end
            i_d     = '0;
            state_d = S_RK_FETCH;
          end
        end
      end
      S_RK_FETCH: begin
        size_raddr = i_q;
        j_d        = '0;
        rank_d     = '0;
        state_d    = S_RK_SWEEP;
      end
      S_RK_SWEEP: begin
        size_raddr = j_q[IDXB-1:0];
        // The first sweep cycle sees the size fetched for the ranked item.
        if (j_q == '0) begin
          si_d = size_rd_q;
        end
        if (cmp_vld_q && greater) begin
          rank_d = rank_q + 1'b1;
        end
        jp_d = j_q[IDXB-1:0];
        if (j_q < cnt_q) begin
          cmp_vld_d = 1'b1;
          j_d       = j_q + 1'b1;
        end else begin
          state_d = S_RK_WR;
        end
      end
      S_RK_WR: begin
        ord_we = 1'b1;
        if (i_next == cnt_q) begin
          k_d     = '0;
          state_d = S_AS_ORD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_RK_FETCH;
        end
      end
      S_AS_ORD: begin
        state_d = S_AS_SIZE;
      end
      S_AS_SIZE: begin
        size_raddr  = ord_rd_q;
        idx_d       = ord_rd_q;
        best_d      = '0;
        best_load_d = loads_q[0];
        b_d         = BSLB'(1);
        state_d     = S_AS_MIN;
      end
      S_AS_MIN: begin
        if (b_q < bins_q) begin
          if (loads_q[b_q[BINB-1:0]] < best_load_q) begin
            best_d      = b_q[BINB-1:0];
            best_load_d = loads_q[b_q[BINB-1:0]];
          end
          b_d = b_q + 1'b1;
        end else begin
          state_d = S_AS_PUSH;
        end
      end
      S_AS_PUSH: begin
        if (push_ok) begin
          out_ld          = 1'b1;
          out_vld_d       = 1'b1;
          loads_d[best_q] = sum;
          if (res_last) begin
            for (int n = 0; n < bbal_pkg::MAX_BINS; n++) begin
              loads_d[n] = '0;
            end
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_AS_ORD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      bincfg_q  <= bbal_pkg::BCFG_BITS'(1);
      bins_q    <= BSLB'(1);
      i_q       <= '0;
      j_q       <= '0;
      cmp_vld_q <= 1'b0;
      rank_q    <= '0;
      k_q       <= '0;
      b_q       <= '0;
      best_q    <= '0;
      out_vld_q <= 1'b0;
      for (int n = 0; n < bbal_pkg::MAX_BINS; n++) begin
        loads_q[n] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      bincfg_q  <= bincfg_d;
      bins_q    <= bins_d;
      i_q       <= i_d;
      j_q       <= j_d;
      cmp_vld_q <= cmp_vld_d;
      rank_q    <= rank_d;
      k_q       <= k_d;
      b_q       <= b_d;
      best_q    <= best_d;
      out_vld_q <= out_vld_d;
      loads_q   <= loads_d;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    jp_q        <= jp_d;
    si_q        <= si_d;
    idx_q       <= idx_d;
    best_load_q <= best_load_d;
    if (out_ld) begin
      out_idx_q  <= idx_q;
      out_bin_q  <= best_q;
      out_load_q <= sum;
      out_drop_q <= ovf_q;
      out_last_q <= res_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[cnt_q[IDXB-1:0]] <= in_i.item_size;
    end
    size_rd_q <= size_mem[size_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[rank_q] <= i_q;
    end
    ord_rd_q <= ord_mem[k_q];
  end

`ifndef SYNTH
  // A rank never points past the items of the batch.
  a_rank_in_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RK_WR) |-> (CNTB'(rank_q) < cnt_q))
    else $error("rank outside the stored batch");

  // The chosen bin is always one of the bins in use.
  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AS_PUSH) |-> (BSLB'(best_q) < bins_q))
    else $error("bin index beyond the bins in use");

  // Closing a batch always leaves at least one stored item to assign.
  a_batch_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.last_item) |=> ((state_q == S_RK_FETCH) && (cnt_q != '0)))
    else $error("batch closed without stored items");

  // The final result of a batch returns the sequencer to loading, cleared.
  a_batch_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_AS_PUSH) && push_ok && res_last)
      |=> ((state_q == S_LOAD) && (cnt_q == '0) && !ovf_q && out_vld_q && out_last_q))
    else $error("batch state not cleared after final result");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for greedy_least_loaded_bin_balancer_core: batches of item
// requests in, one assignment result per stored item out, checked against a local model.
// Depends on bbal_pkg and the channel interfaces in bbal_if.sv.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_ITEMS = bbal_pkg::MAX_ITEMS;
  localparam int MAX_BINS  = bbal_pkg::MAX_BINS;
  localparam int SIZE_BITS = bbal_pkg::SIZE_BITS;
  localparam int IDX_BITS  = bbal_pkg::IDX_BITS;
  localparam int BIN_BITS  = bbal_pkg::BIN_BITS;
  localparam int LOAD_BITS = bbal_pkg::LOAD_BITS;
  localparam int BCFG_BITS = bbal_pkg::BCFG_BITS;

  typedef struct {
    bbal_pkg::size_t size;
    logic            last;
  } item_req_t;

  typedef struct {
    logic [IDX_BITS-1:0] item_index;
    logic [BIN_BITS-1:0] bin_index;
    bbal_pkg::load_t     bin_load;
    logic                dropped;
    logic                last_result;
  } assign_res_t;

  logic clk;
  logic rst_n;

  bbal_in_if  in_if ();
  bbal_out_if out_if ();
  bbal_cfg_if cfg_if ();

  greedy_least_loaded_bin_balancer_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Item requests waiting to be sent, and assignments still owed by the block.
  item_req_t   item_queue[$];
  assign_res_t assign_queue[$];

  // Local copy of the balancer state.
  bbal_pkg::size_t      batch_sizes[MAX_ITEMS];
  int                   batch_count = 0;
  logic                 batch_spilled = 1'b0;
  bbal_pkg::load_t      bin_loads[MAX_BINS];
  logic [BCFG_BITS-1:0] bin_setting = BCFG_BITS'(1);

  int   mismatches = 0;
  bit   item_taken = 1'b0;
  bit   result_taken = 1'b0;
  bit   no_idle = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   items_queued = 0;
  item_req_t next_item;

  // Store one item; on the closing item, rank the batch largest first (stable) and
  // hand each item to the least loaded bin, lowest index on ties.
  function automatic void balance_item(input bbal_pkg::size_t sz, input logic last);
    int          active_bins;
    int          rank[MAX_ITEMS];
    int          j;
    int          best;
    int          idx;
    assign_res_t res;
    if (batch_count < MAX_ITEMS) begin
      batch_sizes[batch_count] = sz;
      batch_count++;
    end else begin
      batch_spilled = 1'b1;
    end
    if (!last) return;
    active_bins = (bin_setting == '0) ? 1 :
                  ((int'(bin_setting) > MAX_BINS) ? MAX_BINS : int'(bin_setting));
    for (int i = 0; i < batch_count; i++) begin
      j = i;
      while (j > 0 && batch_sizes[rank[j-1]] < batch_sizes[i]) begin
        rank[j] = rank[j-1];
        j--;
      end
      rank[j] = i;
    end
    for (int k = 0; k < batch_count; k++) begin
      idx = rank[k];
      best = 0;
      for (int b = 1; b < active_bins; b++) begin
        if (bin_loads[b] < bin_loads[best]) best = b;
      end
      bin_loads[best] = bin_loads[best] + LOAD_BITS'(batch_sizes[idx]);
      res.item_index  = IDX_BITS'(idx);
      res.bin_index   = BIN_BITS'(best);
      res.bin_load    = bin_loads[best];
      res.dropped     = batch_spilled;
      res.last_result = (k + 1 == batch_count);
      assign_queue    = {assign_queue, res};
    end
    batch_count = 0;
    batch_spilled = 1'b0;
    for (int b = 0; b < MAX_BINS; b++) bin_loads[b] = '0;
  endfunction

  // Monitor: every accepted request is seen at the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      item_taken = 1'b0;
      result_taken = 1'b0;
    end else begin
      item_taken = in_if.valid && in_if.ready;
      result_taken = out_if.valid && out_if.ready;
      if (cfg_if.valid && cfg_if.ready) bin_setting = cfg_if.bin_count;
      if (item_taken) balance_item(in_if.item_size, in_if.last_item);
      if (result_taken) begin
        if (assign_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: idx %0d bin %0d load %0d drop %0b last %0b",
                     out_if.item_index, out_if.bin_index, out_if.bin_load,
                     out_if.dropped, out_if.last_result);
        end else begin
          assign_res_t want;
          want = assign_queue.pop_front();
          if (out_if.item_index !== want.item_index || out_if.bin_index !== want.bin_index ||
              out_if.bin_load !== want.bin_load || out_if.dropped !== want.dropped ||
              out_if.last_result !== want.last_result) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected idx %0d bin %0d load %0d drop %0b last %0b",
                       want.item_index, want.bin_index, want.bin_load,
                       want.dropped, want.last_result);
              $display("          actual   idx %0d bin %0d load %0d drop %0b last %0b",
                       out_if.item_index, out_if.bin_index, out_if.bin_load,
                       out_if.dropped, out_if.last_result);
            end
          end
        end
      end
    end
  end

  // Item driver: a random gap follows each accepted request unless no_idle is set.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || item_taken) begin
      if (item_taken) gap_left = no_idle ? 0 : $urandom_range(0, 3);
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (item_queue.size() > 0) begin
        next_item = item_queue.pop_front();
        in_if.valid     <= 1'b1;
        in_if.item_size <= next_item.size;
        in_if.last_item <= next_item.last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: a random stall follows each accepted result unless no_idle is set.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (result_taken) stall_left = no_idle ? 0 : $urandom_range(0, 3);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic bbal_pkg::size_t pick_size(input int kind);
    case (kind)
      0: pick_size = SIZE_BITS'({$urandom(), $urandom()});
      1: pick_size = SIZE_BITS'($urandom_range(0, 7));
      2: case ($urandom_range(0, 2))
           0: pick_size = '0;
           1: pick_size = '1;
           default: pick_size = SIZE_BITS'({$urandom(), $urandom()});
         endcase
      default: pick_size = SIZE_BITS'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic queue_item(input bbal_pkg::size_t sz, input logic last);
    item_req_t it;
    it.size = sz;
    it.last = last;
    item_queue = {item_queue, it};
    items_queued++;
  endtask

  task automatic queue_batch(input int n, input int kind);
    for (int i = 0; i < n; i++) queue_item(pick_size(kind), i == n - 1);
  endtask

  // The block is idle once every request has gone out and every result is back.
  task automatic drain();
    while (item_queue.size() != 0 || in_if.valid || assign_queue.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_bins(input logic [BCFG_BITS-1:0] value);
    @(negedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.bin_count <= value;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.item_size  = '0;
    in_if.last_item  = 1'b0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.bin_count = '0;
    for (int b = 0; b < MAX_BINS; b++) bin_loads[b] = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset value of bin_count is one bin; largest possible size alone.
    queue_item('1, 1'b1);
    drain();

    // Equal sizes keep arrival order around a larger one.
    write_bins(BCFG_BITS'(2));
    queue_item(SIZE_BITS'(5), 1'b0);
    queue_item(SIZE_BITS'(5), 1'b0);
    queue_item(SIZE_BITS'(9), 1'b0);
    queue_item(SIZE_BITS'(5), 1'b1);
    drain();

    // Zero bin count acts as one bin; zero sizes.
    write_bins(BCFG_BITS'(0));
    queue_item(SIZE_BITS'(0), 1'b0);
    queue_item(SIZE_BITS'(3), 1'b0);
    queue_item(SIZE_BITS'(0), 1'b1);
    drain();

    // Bin count above the maximum saturates; more items than bins.
    write_bins(BCFG_BITS'(31));
    queue_batch(17, 1);
    drain();

    // Full batch of the largest size on one bin, several extra items discarded,
    // closed by a discarded last item.
    no_idle = 1'b1;
    write_bins(BCFG_BITS'(1));
    for (int i = 0; i < MAX_ITEMS + 3; i++) queue_item('1, i == MAX_ITEMS + 2);
    drain();

    // Exactly full batch, no overflow.
    no_idle = 1'b0;
    write_bins(BCFG_BITS'($urandom_range(2, 15)));
    queue_batch(MAX_ITEMS, 2);
    drain();

    // Random phases: a new bin count, a few batches, then a full drain.
    while (items_queued < 170) begin
      case ($urandom_range(0, 5))
        0: write_bins(BCFG_BITS'(0));
        1: write_bins(BCFG_BITS'(1));
        2: write_bins(BCFG_BITS'(MAX_BINS));
        3: write_bins(BCFG_BITS'(31));
        default: write_bins(BCFG_BITS'($urandom_range(0, 31)));
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        queue_batch($urandom_range(1, 10), $urandom_range(0, 3));
      end
      drain();
    end

    if (mismatches == 0 && assign_queue.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
